// ----- hw/rtl/exr_pkg.sv -----
// shared constants, types and cordic angle table for the xyz vector rotator
`timescale 1ns / 1ps

package exr_pkg;

    localparam int POS_WIDTH_DEF   = 32;
    localparam int ANGLE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 30;
    localparam int CORDIC_STEPS    = 30;
    localparam int CW              = 34;   // cordic datapath width
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5341269;
            5'd8:  r = 34'sd2670419;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

endpackage

// ----- hw/rtl/exr_cordic_cell.sv -----
// one cordic micro-rotation cell for three angles, carrying the position along
`timescale 1ns / 1ps

module exr_cordic_cell #(
    parameter int STEP = 0,
    parameter int PW   = exr_pkg::POS_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                en,
    input  exr_pkg::cordic_t    c_in  [3],
    input  logic [1:0]          q_in  [3],
    input  logic [3*PW-1:0]     p_in,
    output exr_pkg::cordic_t    c_out [3],
    output logic [1:0]          q_out [3],
    output logic [3*PW-1:0]     p_out
);

    localparam logic signed [exr_pkg::CW-1:0] ATAN = exr_pkg::atan_lut(5'(STEP));

    exr_pkg::cordic_t c_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!c_in[k].z[exr_pkg::CW-1]) begin
                c_next[k].x = c_in[k].x - (c_in[k].y >>> STEP);
                c_next[k].y = c_in[k].y + (c_in[k].x >>> STEP);
                c_next[k].z = c_in[k].z - ATAN;
            end else begin
                c_next[k].x = c_in[k].x + (c_in[k].y >>> STEP);
                c_next[k].y = c_in[k].y - (c_in[k].x >>> STEP);
                c_next[k].z = c_in[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_out <= c_next;
            q_out <= q_in;
            p_out <= p_in;
        end
    end

endmodule

// ----- hw/rtl/exr_rot_cell.sv -----
// one plane rotation cell: two products per output, rounded, over two stages
`timescale 1ns / 1ps

module exr_rot_cell #(
    parameter int IW = 34,
    parameter int OW = 35
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [IW-1:0]               u,
    input  logic signed [IW-1:0]               v,
    input  logic signed [exr_pkg::CW-1:0]      k1a,
    input  logic signed [exr_pkg::CW-1:0]      k2a,
    input  logic signed [exr_pkg::CW-1:0]      k1b,
    input  logic signed [exr_pkg::CW-1:0]      k2b,
    output logic signed [OW-1:0]               ra,
    output logic signed [OW-1:0]               rb
);

    localparam int PW2 = IW + exr_pkg::CW;
    localparam int SW  = PW2 + 1;

    logic signed [PW2-1:0] pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic signed [SW-1:0]  sa_next, sb_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            pa1_reg <= PW2'(u) * PW2'(k1a);
            pa2_reg <= PW2'(v) * PW2'(k2a);
            pb1_reg <= PW2'(u) * PW2'(k1b);
            pb2_reg <= PW2'(v) * PW2'(k2b);
        end
    end

    always_comb begin
        sa_next = SW'(pa1_reg) + SW'(pa2_reg) + SW'(1 <<< (exr_pkg::FRAC_BITS - 1));
        sb_next = SW'(pb1_reg) + SW'(pb2_reg) + SW'(1 <<< (exr_pkg::FRAC_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ra <= OW'(sa_next >>> exr_pkg::FRAC_BITS);
            rb <= OW'(sb_next >>> exr_pkg::FRAC_BITS);
        end
    end

endmodule

// ----- hw/rtl/euler_xyz_vector_rotate.sv -----
// top level: cordic cell chain, three plane rotation cells, saturation and output
`timescale 1ns / 1ps
// pipeline: 30 cordic cells + 1 quadrant stage + 3 rotations of 2 stages + 1 output register
// throughput: one word per cycle; the whole chain advances when the output register is free
// the chain stalls as a unit while the output word waits (s_axis_tready = !valid || ready)
// reset clears only the valid bits along the chain; payload registers are not reset

module euler_xyz_vector_rotate #(
    parameter int POS_WIDTH   = exr_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH = exr_pkg::ANGLE_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z
    input  logic [((3*POS_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // rot_x, rot_y, rot_z, clipped
    output logic [((3*POS_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW   = exr_pkg::CW;
    localparam int NS   = exr_pkg::CORDIC_STEPS;
    localparam int LAT  = NS + 1 + 6 + 1;
    localparam int W1   = POS_WIDTH + 2;
    localparam int W2   = POS_WIDTH + 3;
    localparam int W3   = POS_WIDTH + 4;
    localparam int OUTW = ((3*POS_WIDTH+1+7)/8)*8;

    logic en;
    logic [LAT-2:0] vld_reg;
    logic           out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LAT-3:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[LAT-2];
        end
    end

    // cordic chain
    exr_pkg::cordic_t c_ch [NS+1][3];
    logic [1:0]       q_ch [NS+1][3];
    logic [3*POS_WIDTH-1:0] p_ch [NS+1];

    always_comb begin
        p_ch[0] = s_axis_tdata[3*POS_WIDTH-1:0];
        for (int k = 0; k < 3; k++) begin
            logic [31:0] ph;
            ph = 32'(s_axis_tdata[3*POS_WIDTH+k*ANGLE_WIDTH +: ANGLE_WIDTH]) <<
                 (32 - ANGLE_WIDTH);
            q_ch[0][k]   = ph[31:30];
            c_ch[0][k].x = exr_pkg::CORDIC_GAIN;
            c_ch[0][k].y = '0;
            c_ch[0][k].z = CW'({2'b00, ph[29:0]});
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        exr_cordic_cell #(.STEP(i), .PW(POS_WIDTH)) u_cell (
            .aclk (aclk), .en (en),
            .c_in (c_ch[i]),   .q_in (q_ch[i]),   .p_in (p_ch[i]),
            .c_out(c_ch[i+1]), .q_out(q_ch[i+1]), .p_out(p_ch[i+1])
        );
    end

    // quadrant mapping
    logic signed [CW-1:0] cs_reg [3];
    logic signed [CW-1:0] sn_reg [3];
    logic signed [POS_WIDTH-1:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                case (q_ch[NS][k])
                    2'd0: begin cs_reg[k] <= c_ch[NS][k].x;  sn_reg[k] <= c_ch[NS][k].y;  end
                    2'd1: begin cs_reg[k] <= -c_ch[NS][k].y; sn_reg[k] <= c_ch[NS][k].x;  end
                    2'd2: begin cs_reg[k] <= -c_ch[NS][k].x; sn_reg[k] <= -c_ch[NS][k].y; end
                    default: begin
                        cs_reg[k] <= c_ch[NS][k].y; sn_reg[k] <= -c_ch[NS][k].x;
                    end
                endcase
            end
            px_reg <= p_ch[NS][POS_WIDTH-1:0];
            py_reg <= p_ch[NS][2*POS_WIDTH-1:POS_WIDTH];
            pz_reg <= p_ch[NS][3*POS_WIDTH-1:2*POS_WIDTH];
        end
    end

    // delay lines for the later rotations
    logic signed [CW-1:0] cb_d [2], sb_d [2], cc_d [4], sc_d [4];
    logic signed [POS_WIDTH-1:0] x_d [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            cb_d[0] <= cs_reg[1]; sb_d[0] <= sn_reg[1];
            cb_d[1] <= cb_d[0];   sb_d[1] <= sb_d[0];
            cc_d[0] <= cs_reg[2]; sc_d[0] <= sn_reg[2];
            for (int j = 1; j < 4; j++) begin
                cc_d[j] <= cc_d[j-1]; sc_d[j] <= sc_d[j-1];
            end
            x_d[0] <= px_reg;
            x_d[1] <= x_d[0];
        end
    end

    // about x by -a
    logic signed [W1-1:0] y1, z1;
    exr_rot_cell #(.IW(POS_WIDTH), .OW(W1)) u_rx (
        .aclk(aclk), .en(en), .u(py_reg), .v(pz_reg),
        .k1a(cs_reg[0]), .k2a(sn_reg[0]), .k1b(-sn_reg[0]), .k2b(cs_reg[0]),
        .ra(y1), .rb(z1)
    );

    // about y by -b
    logic signed [W2-1:0] x2, z2;
    logic signed [W1-1:0] y_d [2];
    always_ff @(posedge aclk) begin
        if (en) begin
            y_d[0] <= y1;
            y_d[1] <= y_d[0];
        end
    end
    exr_rot_cell #(.IW(W1), .OW(W2)) u_ry (
        .aclk(aclk), .en(en), .u(W1'(x_d[1])), .v(z1),
        .k1a(cb_d[1]), .k2a(-sb_d[1]), .k1b(sb_d[1]), .k2b(cb_d[1]),
        .ra(x2), .rb(z2)
    );

    // about z by -c
    logic signed [W3-1:0] x3, y3;
    logic signed [W2-1:0] z_d [2];
    always_ff @(posedge aclk) begin
        if (en) begin
            z_d[0] <= z2;
            z_d[1] <= z_d[0];
        end
    end
    exr_rot_cell #(.IW(W2), .OW(W3)) u_rz (
        .aclk(aclk), .en(en), .u(x2), .v(W2'(y_d[1])),
        .k1a(cc_d[3]), .k2a(sc_d[3]), .k1b(-sc_d[3]), .k2b(cc_d[3]),
        .ra(x3), .rb(y3)
    );

    // saturation
    localparam logic signed [W3-1:0] HI = W3'((64'sd1 <<< (POS_WIDTH-1)) - 1);
    localparam logic signed [W3-1:0] LO = -HI - W3'(1);

    logic [2:0] clip_c;
    logic [POS_WIDTH-1:0] sat [3];
    logic signed [W3-1:0] comp [3];
    logic [OUTW-1:0] out_reg;

    always_comb begin
        comp[0] = x3;
        comp[1] = y3;
        comp[2] = W3'(z_d[1]);
        for (int k = 0; k < 3; k++) begin
            clip_c[k] = 1'b1;
            if (comp[k] > HI)      sat[k] = HI[POS_WIDTH-1:0];
            else if (comp[k] < LO) sat[k] = LO[POS_WIDTH-1:0];
            else begin
                sat[k]    = comp[k][POS_WIDTH-1:0];
                clip_c[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= OUTW'({|clip_c, sat[2], sat[1], sat[0]});
        end
    end

    assign m_axis_tdata = out_reg;

endmodule

// ----- hw/rtl/exr_checker.sv -----
// port-level checker for the xyz vector rotator, bound to the top level
`timescale 1ns / 1ps

module exr_checker #(
    parameter int OUTW = 104
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_axis_tready,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [OUTW-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind euler_xyz_vector_rotate exr_checker #(.OUTW(OUTW)) u_exr_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
